// ===== design/oscillator_bank_tick_unit_assert.svh =====
// ----------------------------------------------------------------------------
// oscillator_bank_tick_unit_assert.svh
// Assertion macros shared by the oscillator bank modules.
// ----------------------------------------------------------------------------
`ifndef OSCILLATOR_BANK_TICK_UNIT_ASSERT_SVH
`define OSCILLATOR_BANK_TICK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define OBTU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Checked on every rising edge, reset included.
`define OBTU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define OBTU_ASSERT(label, prop, msg)
`define OBTU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/obtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obtu_pkg
// Types, constants and baseline tables of the oscillator bank tick unit.
// ----------------------------------------------------------------------------
package obtu_pkg;

    localparam int MAX_OSC    = 16;
    localparam int OSC_IDX_W  = 4;
    localparam int VAL_W      = 16;
    localparam int FREQ_W     = 4;
    localparam int AMP_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_A     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_B     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_C     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_D     = 3'd5;

    localparam logic [CFG_DATA_W-1:0] RST_FREQ_LOW  = 32'd1216619042;
    localparam logic [CFG_DATA_W-1:0] RST_FREQ_HIGH = 32'd578105890;
    localparam logic [CFG_DATA_W-1:0] RST_AMP_A     = 32'd807409680;
    localparam logic [CFG_DATA_W-1:0] RST_AMP_B     = 32'd1077938208;
    localparam logic [CFG_DATA_W-1:0] RST_AMP_C     = 32'd807424080;
    localparam logic [CFG_DATA_W-1:0] RST_AMP_D     = 32'd269512784;

    // per-item operation, latched at the input transfer
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_ADV    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;

    localparam logic [VAL_W-1:0] BASE_REST_VALUE = 16'h0080;

    typedef struct packed {
        logic                 step;
        logic [MODE_W-1:0]    mode;
        logic [OSC_IDX_W-1:0] idx;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [VAL_W-1:0] base_value(input logic [OSC_IDX_W-1:0] k);
        logic [VAL_W-1:0] v;
        case (k)
            4'd9:    v = 16'h50f0;
            4'd10:   v = 16'h2080;
            4'd11:   v = 16'h3080;
            4'd12:   v = 16'h5080;
            4'd13:   v = 16'h7080;
            default: v = BASE_REST_VALUE;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] base_velocity(input logic [OSC_IDX_W-1:0] k);
        logic [VAL_W-1:0] v;
        case (k)
            4'd9:    v = 16'h011e;
            4'd10:   v = 16'h00b4;
            4'd11:   v = 16'h010e;
            4'd12:   v = 16'h01c2;
            4'd13:   v = 16'h0276;
            default: v = '0;
        endcase
        return v;
    endfunction

    // direction word 0x007C with oscillator k at bit 15-k
    function automatic logic base_falling(input logic [OSC_IDX_W-1:0] k);
        return (k inside {[4'd9:4'd13]});
    endfunction

endpackage

// ===== design/obtu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obtu_if
// Valid/ready channel interfaces: item input, result output, register write.
// ----------------------------------------------------------------------------
interface obtu_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic hold;

    modport source (output valid, output operation, output hold, input ready);
    modport sink   (input valid, input operation, input hold, output ready);
endinterface

interface obtu_out_if import obtu_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OSC_IDX_W-1:0] osc_index;
    logic [VAL_W-1:0]     osc_value;
    logic                 falling;
    logic                 is_last;

    modport source (output valid, output osc_index, output osc_value,
                    output falling, output is_last, input ready);
    modport sink   (input valid, input osc_index, input osc_value,
                    input falling, input is_last, output ready);
endinterface

interface obtu_cfg_if import obtu_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/obtu_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obtu_cfg
// Frequency and amplitude registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module obtu_cfg import obtu_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic [MAX_OSC*FREQ_W-1:0]     o_freq,
    output logic [MAX_OSC*AMP_W-1:0]      o_amp
);

    logic [CFG_DATA_W-1:0] r_freq_low, r_freq_high;
    logic [CFG_DATA_W-1:0] r_amp_a, r_amp_b, r_amp_c, r_amp_d;
    logic                  w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_low  <= RST_FREQ_LOW;
            r_freq_high <= RST_FREQ_HIGH;
            r_amp_a     <= RST_AMP_A;
            r_amp_b     <= RST_AMP_B;
            r_amp_c     <= RST_AMP_C;
            r_amp_d     <= RST_AMP_D;
        end else if (w_wr) begin
            case (i_cfg_index)
                CFG_FREQ_LOW:  r_freq_low  <= i_cfg_data;
                CFG_FREQ_HIGH: r_freq_high <= i_cfg_data;
                CFG_AMP_A:     r_amp_a     <= i_cfg_data;
                CFG_AMP_B:     r_amp_b     <= i_cfg_data;
                CFG_AMP_C:     r_amp_c     <= i_cfg_data;
                CFG_AMP_D:     r_amp_d     <= i_cfg_data;
                default: ;     // writes past the list are dropped
            endcase
        end
    end

    assign o_freq = {r_freq_high, r_freq_low};
    assign o_amp  = {r_amp_d, r_amp_c, r_amp_b, r_amp_a};

endmodule

// ===== design/obtu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obtu_ctrl
// Sequencer: takes an item, then steps the datapath over every oscillator.
// ----------------------------------------------------------------------------
`include "oscillator_bank_tick_unit_assert.svh"

module obtu_ctrl import obtu_pkg::*; #(
    parameter int NUM_OSC = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_in_operation,
    input  logic i_in_hold,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;
    localparam logic [OSC_IDX_W-1:0] LAST_IDX = OSC_IDX_W'(NUM_OSC - 1);

    logic                 r_state, n_state;
    logic [OSC_IDX_W-1:0] r_idx, n_idx;
    logic [MODE_W-1:0]    r_mode, n_mode;
    logic                 w_step, w_last;

    assign w_last = (r_idx == LAST_IDX);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_mode     = r_mode;
        o_in_ready = 1'b0;
        w_step     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_state = S_RUN;
                    if (i_in_operation) begin
                        n_mode = MODE_RELOAD;   // reload ignores hold
                    end else if (i_in_hold) begin
                        n_mode = MODE_HOLD;
                    end else begin
                        n_mode = MODE_ADV;
                    end
                end
            end
            S_RUN: begin
                w_step = i_sts.out_free;
                if (w_step) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_mode  <= MODE_ADV;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
        end
    end

    assign o_cmd.step = w_step;
    assign o_cmd.mode = r_mode;
    assign o_cmd.idx  = r_idx;
    assign o_cmd.last = w_last;

    `OBTU_ASSERT(a_start_at_zero, (i_in_valid && o_in_ready) |=> (r_state == S_RUN && r_idx == '0), "item transfer did not start a pass at oscillator 0")
    `OBTU_ASSERT(a_idx_in_range, r_idx <= LAST_IDX, "oscillator counter past the last oscillator")
    `OBTU_ASSERT(a_stall_holds_idx, (r_state == S_RUN && !w_step) |=> $stable(r_idx), "counter moved while the result stage was stalled")

endmodule

// ===== design/obtu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obtu_dp
// Oscillator state, the shared velocity/value adder pair and the result stage.
// ----------------------------------------------------------------------------
`include "oscillator_bank_tick_unit_assert.svh"

module obtu_dp import obtu_pkg::*; #(
    parameter int NUM_OSC = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic [MAX_OSC*FREQ_W-1:0] i_freq,
    input  logic [MAX_OSC*AMP_W-1:0]  i_amp,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [OSC_IDX_W-1:0]      o_out_osc_index,
    output logic [VAL_W-1:0]          o_out_osc_value,
    output logic                      o_out_falling,
    output logic                      o_out_is_last
);

    localparam int IDX_W = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;

    logic [VAL_W-1:0]     r_val [NUM_OSC];
    logic [VAL_W-1:0]     r_vel [NUM_OSC];
    logic [NUM_OSC-1:0]   r_dir;

    logic                 r_out_valid, n_out_valid;
    logic [OSC_IDX_W-1:0] r_out_idx;
    logic [VAL_W-1:0]     r_out_value;
    logic                 r_out_falling;
    logic                 r_out_last;

    logic [IDX_W-1:0]     w_k;
    logic [FREQ_W-1:0]    w_freq;
    logic [AMP_W-1:0]     w_amp;
    logic [VAL_W-1:0]     w_cur_val, w_cur_vel;
    logic                 w_cur_dir;
    logic [VAL_W-1:0]     w_adv_vel, w_adv_val;
    logic                 w_adv_dir;
    logic [VAL_W-1:0]     w_new_val, w_new_vel;
    logic                 w_new_dir;

    assign w_k       = i_cmd.idx[IDX_W-1:0];
    assign w_freq    = i_freq[{i_cmd.idx, 2'b00} +: FREQ_W];
    assign w_amp     = i_amp[{i_cmd.idx, 3'b000} +: AMP_W];
    assign w_cur_val = r_val[w_k];
    assign w_cur_vel = r_vel[w_k];
    assign w_cur_dir = r_dir[w_k];

    // falling subtracts the step, rising adds it; either way the new
    // direction is simply "high byte at or above amplitude"
    assign w_adv_vel = w_cur_dir ? (w_cur_vel - VAL_W'(w_freq))
                                 : (w_cur_vel + VAL_W'(w_freq));
    assign w_adv_val = w_cur_val + w_adv_vel;
    assign w_adv_dir = (w_adv_val[VAL_W-1 -: AMP_W] >= w_amp);

    always_comb begin
        case (i_cmd.mode)
            MODE_ADV: begin
                w_new_val = w_adv_val;
                w_new_vel = w_adv_vel;
                w_new_dir = w_adv_dir;
            end
            MODE_RELOAD: begin
                w_new_val = base_value(i_cmd.idx);
                w_new_vel = base_velocity(i_cmd.idx);
                w_new_dir = base_falling(i_cmd.idx);
            end
            default: begin
                w_new_val = w_cur_val;
                w_new_vel = w_cur_vel;
                w_new_dir = w_cur_dir;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_OSC; i++) begin
                r_val[i] <= base_value(OSC_IDX_W'(i));
                r_vel[i] <= base_velocity(OSC_IDX_W'(i));
                r_dir[i] <= base_falling(OSC_IDX_W'(i));
            end
        end else if (i_cmd.step) begin
            r_val[w_k] <= w_new_val;
            r_vel[w_k] <= w_new_vel;
            r_dir[w_k] <= w_new_dir;
        end
    end

    // result stage: refilled in the same cycle its content transfers
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_idx     <= i_cmd.idx;
            r_out_value   <= w_new_val;
            r_out_falling <= w_new_dir;
            r_out_last    <= i_cmd.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_osc_index = r_out_idx;
    assign o_out_osc_value = r_out_value;
    assign o_out_falling   = r_out_falling;
    assign o_out_is_last   = r_out_last;

    `OBTU_ASSERT(a_out_dir_matches, r_out_valid |-> (r_out_falling == r_dir[r_out_idx[IDX_W-1:0]]), "reported direction differs from stored direction")
    `OBTU_ASSERT_ALWAYS(a_last_index, (r_out_valid && r_out_last) |-> (r_out_idx == OSC_IDX_W'(NUM_OSC - 1)), "last flag on a result that is not the final oscillator")

endmodule

// ===== design/oscillator_bank_tick_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oscillator_bank_tick_unit
// Bank of oscillators advanced, held or reloaded per item; one result each.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                 transfer
//  i_in      in   operation, hold                         valid & ready
//  o_out     out  osc_index, osc_value, falling, is_last  valid & ready
//  i_cfg     in   index (3b), data (32b)                  valid & ready
//
//  An item is taken first, then one oscillator per cycle while the output
//  register is free, each through the shared velocity/value adder pair and
//  into the output register. A stalled output register halts the pass.
//  The next item is taken while the last result still waits.
//  Reset restores the baseline oscillator state and the register defaults
//  directly; no clearing pass.
// ----------------------------------------------------------------------------
module oscillator_bank_tick_unit import obtu_pkg::*; #(
    parameter int NUM_OSC = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    obtu_in_if.sink           i_in,
    obtu_out_if.source        o_out,
    obtu_cfg_if.sink          i_cfg
);

    t_cmd                      w_cmd;
    t_sts                      w_sts;
    logic [MAX_OSC*FREQ_W-1:0] w_freq;
    logic [MAX_OSC*AMP_W-1:0]  w_amp;

    obtu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_freq      (w_freq),
        .o_amp       (w_amp)
    );

    obtu_ctrl #(
        .NUM_OSC (NUM_OSC)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_in_operation (i_in.operation),
        .i_in_hold      (i_in.hold),
        .i_sts          (w_sts),
        .o_cmd          (w_cmd)
    );

    obtu_dp #(
        .NUM_OSC (NUM_OSC)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_freq          (w_freq),
        .i_amp           (w_amp),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_out_osc_index (o_out.osc_index),
        .o_out_osc_value (o_out.osc_value),
        .o_out_falling   (o_out.falling),
        .o_out_is_last   (o_out.is_last)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the oscillator bank tick unit. Tick, hold and
// reload items are streamed through the input channel under random idling
// on both sides. Each input transfer runs a cycle-free model of the bank
// that queues the sixteen reports it should produce. Every output transfer
// is checked field by field against the oldest queued report. The
// register set is rewritten between phases while the bank is idle.
// ----------------------------------------------------------------------------
module testbench;
    import obtu_pkg::*;

    localparam int NUM_OSC     = 16;
    localparam int NUM_REGS    = 6;
    localparam int LONG_STALL  = 400;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 40;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RELOAD = 1'b1;

    localparam logic [VAL_W-1:0] BASE_VAL [MAX_OSC] = '{
        16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080, 16'h0080,
        16'h0080, 16'h50f0, 16'h2080, 16'h3080, 16'h5080, 16'h7080, 16'h0080, 16'h0080
    };
    localparam logic [VAL_W-1:0] BASE_VEL [MAX_OSC] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h011e, 16'h00b4, 16'h010e, 16'h01c2, 16'h0276, 16'h0000, 16'h0000
    };
    // oscillator k at bit 15-k
    localparam logic [MAX_OSC-1:0] BASE_FALLING = 16'h007C;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX [NUM_REGS] = '{
        CFG_FREQ_LOW, CFG_FREQ_HIGH, CFG_AMP_A, CFG_AMP_B, CFG_AMP_C, CFG_AMP_D
    };

    typedef struct packed {
        logic operation;
        logic hold;
    } tick_item_t;

    typedef struct packed {
        logic [OSC_IDX_W-1:0] index;
        logic [VAL_W-1:0]     value;
        logic                 falling;
        logic                 last;
    } osc_report_t;

    typedef logic [CFG_DATA_W-1:0] reg_set_t [NUM_REGS];

    logic i_clk;
    logic i_rst_n;

    obtu_in_if  in_ch ();
    obtu_out_if out_ch ();
    obtu_cfg_if cfg_ch ();

    oscillator_bank_tick_unit #(
        .NUM_OSC (NUM_OSC)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    tick_item_t  tick_queue [$];
    osc_report_t expected_reports [$];
    int          fail_count;
    logic        quiet_mode;
    logic        rx_block_req;
    int          rx_block_count;
    logic        rx_blocked;
    int          tx_gap;
    int          rx_gap;

    // bank model
    logic [VAL_W-1:0]      model_val [MAX_OSC];
    logic [VAL_W-1:0]      model_vel [MAX_OSC];
    logic [MAX_OSC-1:0]    model_falling;
    logic [CFG_DATA_W-1:0] model_regs [NUM_REGS];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic load_base_model();
        for (int k = 0; k < MAX_OSC; k++) begin
            model_val[k] = BASE_VAL[k];
            model_vel[k] = BASE_VEL[k];
        end
        model_falling = BASE_FALLING;
    endtask

    task automatic predict_reports(input tick_item_t item);
        logic [CFG_DATA_W-1:0] fw;
        logic [CFG_DATA_W-1:0] aw;
        logic [FREQ_W-1:0]     f;
        logic [AMP_W-1:0]      a;
        osc_report_t           rep;
        if (item.operation == OP_RELOAD) begin
            load_base_model();
        end else if (!item.hold) begin
            for (int k = 0; k < NUM_OSC; k++) begin
                fw = (k < 8) ? model_regs[CFG_FREQ_LOW] : model_regs[CFG_FREQ_HIGH];
                f  = fw[(k % 8) * FREQ_W +: FREQ_W];
                aw = model_regs[CFG_AMP_A + k / 4];
                a  = aw[(k % 4) * AMP_W +: AMP_W];
                if (model_falling[MAX_OSC-1-k]) begin
                    model_vel[k] = model_vel[k] - VAL_W'(f);
                    model_val[k] = model_val[k] + model_vel[k];
                    if (model_val[k][VAL_W-1 -: AMP_W] < a) begin
                        model_falling[MAX_OSC-1-k] = 1'b0;
                    end
                end else begin
                    model_vel[k] = model_vel[k] + VAL_W'(f);
                    model_val[k] = model_val[k] + model_vel[k];
                    if (model_val[k][VAL_W-1 -: AMP_W] >= a) begin
                        model_falling[MAX_OSC-1-k] = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < NUM_OSC; k++) begin
            rep.index   = OSC_IDX_W'(k);
            rep.value   = model_val[k];
            rep.falling = model_falling[MAX_OSC-1-k];
            rep.last    = (k == NUM_OSC - 1);
            expected_reports.push_back(rep);
        end
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // model update and result check
    always @(posedge i_clk) begin
        osc_report_t want;
        if (!i_rst_n) begin
            load_base_model();
            model_regs[CFG_FREQ_LOW]  = RST_FREQ_LOW;
            model_regs[CFG_FREQ_HIGH] = RST_FREQ_HIGH;
            model_regs[CFG_AMP_A]     = RST_AMP_A;
            model_regs[CFG_AMP_B]     = RST_AMP_B;
            model_regs[CFG_AMP_C]     = RST_AMP_C;
            model_regs[CFG_AMP_D]     = RST_AMP_D;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                model_regs[cfg_ch.index] = cfg_ch.data;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, actual index %0d",
                             $time, out_ch.osc_index);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("osc_index", VAL_W'(want.index), VAL_W'(out_ch.osc_index));
                    check_field("osc_value", want.value, out_ch.osc_value);
                    check_field("falling", VAL_W'(want.falling), VAL_W'(out_ch.falling));
                    check_field("is_last", VAL_W'(want.last), VAL_W'(out_ch.is_last));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predict_reports('{operation: in_ch.operation, hold: in_ch.hold});
            end
        end
    end

    // item driver
    always @(posedge i_clk) begin
        tick_item_t item;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            tx_gap = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (tx_gap != 0) begin
                tx_gap--;
                in_ch.valid <= 1'b0;
            end else if (tick_queue.size() != 0 && !quiet_mode &&
                         $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(0, 14);
                in_ch.valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                item = tick_queue.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.operation <= item.operation;
                in_ch.hold      <= item.hold;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted apart from the random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_block_count <= 0;
        end else if (rx_block_req && rx_block_count < LONG_STALL) begin
            rx_block_count <= rx_block_count + 1;
        end
    end
    assign rx_blocked = rx_block_req && (rx_block_count < LONG_STALL);

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end else if (rx_blocked) begin
            out_ch.ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            out_ch.ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 14);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic op, input logic hold);
        tick_queue.push_back('{operation: op, hold: hold});
    endtask

    // returns at a falling edge once every item has gone and every report came
    task automatic drain_bank();
        while (tick_queue.size() != 0 || in_ch.valid || expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_config(input reg_set_t regs);
        @(posedge i_clk);
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= REG_INDEX[r];
            cfg_ch.data  <= regs[r];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        reg_set_t phase_regs;
        int       r;
        logic     op;
        logic     hold;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.hold      = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_FREQ_LOW;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        quiet_mode      = 1'b0;
        rx_block_req    = 1'b0;
        fail_count      = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: plain ticks, hold, reload, reload with hold set
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_RELOAD, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_RELOAD, 1'b1);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        drain_bank();

        // zero frequencies and amplitudes
        phase_regs = '{default: '0};
        load_config(phase_regs);
        @(negedge i_clk);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b1);
        queue_item(OP_RELOAD, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        drain_bank();

        // every field at its maximum
        phase_regs = '{default: '1};
        load_config(phase_regs);
        @(negedge i_clk);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_RELOAD, 1'b1);
        queue_item(OP_TICK, 1'b0);
        queue_item(OP_TICK, 1'b0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_bank();
            for (int g = 0; g < NUM_REGS; g++) begin
                case ($urandom_range(0, 5))
                    0:       phase_regs[g] = '0;
                    1:       phase_regs[g] = '1;
                    default: phase_regs[g] = $urandom;
                endcase
            end
            if (p == 3) begin
                phase_regs = '{RST_FREQ_LOW, RST_FREQ_HIGH, RST_AMP_A,
                               RST_AMP_B, RST_AMP_C, RST_AMP_D};
            end
            load_config(phase_regs);
            @(negedge i_clk);
            // mostly running ticks so the oscillators travel far from baseline
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r    = $urandom_range(0, 31);
                op   = (r == 0) ? OP_RELOAD : OP_TICK;
                hold = (r == 0) ? 1'($urandom_range(0, 1)) : (r < 4);
                queue_item(op, hold);
            end
            if (p == 2) begin
                rx_block_req = 1'b1;
            end
            if (p == RAND_PHASES - 1) begin
                quiet_mode = 1'b1;
            end
        end

        drain_bank();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
